FILE: hdl/takf_pkg.sv
// shared types and constants for the tilt angle kalman filter
`timescale 1ns / 1ps
package takf_pkg;

	localparam int unsigned CFG_WIDTH  = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned COV_WIDTH  = 32;
	localparam int unsigned DT_FRAC    = 24;
	localparam int unsigned OUT_WIDTH  = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OBS_GAIN    = 3'd4;

	typedef struct packed {
		logic signed [24:0] measured_angle;
		logic signed [31:0] gyro_rate;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] angle_estimate;
		logic signed [31:0] rate_estimate;
		logic signed [31:0] bias_estimate;
	} out_item_t;

endpackage

FILE: hdl/takf_mul.sv
// shared signed multiplier with rounding shift and saturation; the product and the result are registered
`timescale 1ns / 1ps
module takf_mul #(
	parameter int unsigned OP_W = 32
) (
	input  logic                   clk,
	input  logic signed [OP_W-1:0] a,
	input  logic signed [OP_W-1:0] b,
	input  logic [5:0]             sh,
	input  logic [5:0]             w,
	output logic signed [OP_W-1:0] y
);
	localparam int unsigned PW = 2 * OP_W;

	logic [PW-1:0]   prod_s1;
	logic            neg_s1;
	logic [5:0]      sh_s1;
	logic [5:0]      w_s1;
	logic [OP_W-1:0] ua;
	logic [OP_W-1:0] ub;
	logic [PW:0]     rnd;
	logic [PW:0]     shd;
	logic [PW:0]     lim;

	assign ua = a[OP_W-1] ? OP_W'(-a) : a;
	assign ub = b[OP_W-1] ? OP_W'(-b) : b;

	// stage one: magnitude product
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(ua) * PW'(ub);
		neg_s1  <= a[OP_W-1] ^ b[OP_W-1];
		sh_s1   <= sh;
		w_s1    <= w;
	end

	// stage two: round half away, shift, saturate
	always_comb begin
		rnd = (PW+1)'(prod_s1);
		if (sh_s1 != 6'd0)
			rnd = rnd + ((PW+1)'(1) << (sh_s1 - 6'd1));
		shd = rnd >> sh_s1;
		lim = ((PW+1)'(1) << (w_s1 - 6'd1)) - (neg_s1 ? (PW+1)'(0) : (PW+1)'(1));
		if (shd > lim)
			shd = lim;
	end

	always_ff @(posedge clk) begin
		y <= neg_s1 ? OP_W'(-shd) : OP_W'(shd);
	end

endmodule

FILE: hdl/takf_div.sv
// radix-two restoring divider for the gain quotients, saturated to 32 bits
`timescale 1ns / 1ps
module takf_div #(
	parameter int unsigned FRAC = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int unsigned NW = 32 + FRAC;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [NW-1:0] qt_q;
	logic [32:0]   rem_q;
	logic [31:0]   dsr_q;
	logic          neg_q;
	logic          zero_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [32:0]   trial;
	logic [NW-1:0] qmag;
	logic [31:0]   lim;

	assign trial = {rem_q[31:0], dvd_q[NW-1]};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {(num[31] ? 32'(-num) : num), FRAC'(0)};
			dsr_q  <= den[31] ? 32'(-den) : den;
			neg_q  <= num[31] ^ den[31];
			zero_q <= (den == 32'sd0);
			rem_q  <= '0;
			qt_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				qt_q  <= {qt_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				qt_q  <= {qt_q[NW-2:0], 1'b0};
			end
		end
	end

	// saturate and sign the quotient; a zero divisor gives zero
	always_comb begin
		lim  = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		qmag = (qt_q > NW'(lim)) ? NW'(lim) : qt_q;
		if (zero_q)
			quo = '0;
		else
			quo = neg_q ? 32'(-qmag) : qmag[31:0];
	end

endmodule

FILE: hdl/tilt_angle_kalman_filter_core.sv
// top level: filter state, sequencer and shared arithmetic
// an item is processed in the rate step, 15 multiplier steps (issue, wait, take result)
// and two divider passes for the gains
// in_stall is high from acceptance until the result has been taken
// reset clears the state to angle and bias zero, covariance identity, and loads defaults
`timescale 1ns / 1ps
module tilt_angle_kalman_filter_core #(
	parameter int unsigned DATA_WIDTH    = 32,
	parameter int unsigned COV_FRAC_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  takf_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output takf_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [takf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [takf_pkg::CFG_WIDTH-1:0]       cfg_value
);
	localparam int unsigned OPW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam int unsigned CW  = takf_pkg::COV_WIDTH;

	typedef enum logic [4:0] {
		S_IDLE, S_RATE, S_ANG, S_P0, S_P1, S_P2, S_P3,
		S_PCT0, S_PCT1, S_E, S_K0, S_K1, S_T1,
		S_C0, S_C1, S_C2, S_C3, S_CA, S_CB, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] wait_q;
	logic       issued_q;

	logic [23:0]          dt_q;
	logic [30:0]          qa_q;
	logic [30:0]          qb_q;
	logic [30:0]          rn_q;
	logic signed [31:0]   c_q;

	logic signed [DATA_WIDTH-1:0] ang_q;
	logic signed [DATA_WIDTH-1:0] bias_q;
	logic signed [DATA_WIDTH-1:0] rate_q;
	logic signed [DATA_WIDTH-1:0] err_q;
	logic signed [DATA_WIDTH-1:0] gyro_q;
	logic signed [DATA_WIDTH-1:0] meas_q;
	logic signed [CW-1:0] p0_q, p1_q, p2_q, p3_q;
	logic signed [CW-1:0] pct0_q, pct1_q, t1_q, e_q, k0_q, k1_q;

	logic signed [OPW-1:0] ma;
	logic signed [OPW-1:0] mb;
	logic [5:0]            msh;
	logic [5:0]            mw;
	logic signed [OPW-1:0] my;

	logic                  dstart;
	logic signed [31:0]    dnum;
	logic                  ddone;
	logic signed [31:0]    dquo;

	takf_pkg::out_item_t res_q;

	takf_mul #(.OP_W(OPW)) u_mul (
		.clk(clk), .a(ma), .b(mb), .sh(msh), .w(mw), .y(my)
	);

	takf_div #(.FRAC(COV_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(e_q),
		.done(ddone), .quo(dquo)
	);

	// saturation helpers for the sums and the 32-bit outputs
	function automatic logic signed [OPW-1:0] sat_d(input logic signed [OPW+1:0] v);
		logic signed [OPW+1:0] hi;
		logic signed [OPW+1:0] lo;
		hi = (OPW+2)'((65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1);
		lo = -hi - (OPW+2)'(1);
		if (v > hi) sat_d = OPW'(hi);
		else if (v < lo) sat_d = OPW'(lo);
		else sat_d = OPW'(v);
	endfunction

	function automatic logic signed [CW-1:0] sat_c(input logic signed [CW+1:0] v);
		if (v > (CW+2)'(34'sh0_7FFF_FFFF)) sat_c = 32'sh7FFF_FFFF;
		else if (v < -(CW+2)'(34'sh0_8000_0000)) sat_c = 32'sh8000_0000;
		else sat_c = CW'(v);
	endfunction

	function automatic logic signed [31:0] sat_o(input logic signed [DATA_WIDTH-1:0] v);
		logic signed [DATA_WIDTH+1:0] x;
		x = (DATA_WIDTH+2)'(v);
		if (x > (DATA_WIDTH+2)'(34'sh0_7FFF_FFFF)) sat_o = 32'sh7FFF_FFFF;
		else if (x < -(DATA_WIDTH+2)'(34'sh0_8000_0000)) sat_o = 32'sh8000_0000;
		else sat_o = 32'(v);
	endfunction

	// multiplier operand selection per step
	always_comb begin
		ma  = '0;
		mb  = '0;
		msh = 6'(COV_FRAC_BITS);
		mw  = 6'(CW);
		case (state_q)
			S_ANG: begin
				ma = OPW'(rate_q); mb = OPW'({1'b0, dt_q});
				msh = 6'(takf_pkg::DT_FRAC); mw = 6'(DATA_WIDTH);
			end
			S_P0: begin
				ma = OPW'(sat_c((CW+2)'($signed({1'b0, qa_q})) - (CW+2)'(p1_q)
					- (CW+2)'(p2_q)));
				mb = OPW'({1'b0, dt_q}); msh = 6'(takf_pkg::DT_FRAC);
			end
			S_P1, S_P2: begin
				ma = OPW'(sat_c(-(CW+2)'(p3_q)));
				mb = OPW'({1'b0, dt_q}); msh = 6'(takf_pkg::DT_FRAC);
			end
			S_P3: begin
				ma = OPW'($signed({1'b0, qb_q}));
				mb = OPW'({1'b0, dt_q}); msh = 6'(takf_pkg::DT_FRAC);
			end
			S_PCT0: begin ma = OPW'(c_q); mb = OPW'(p0_q); end
			S_PCT1: begin ma = OPW'(c_q); mb = OPW'(p2_q); end
			S_E:    begin ma = OPW'(c_q); mb = OPW'(pct0_q); end
			S_T1:   begin ma = OPW'(c_q); mb = OPW'(p1_q); end
			S_C0:   begin ma = OPW'(k0_q); mb = OPW'(pct0_q); end
			S_C1:   begin ma = OPW'(k0_q); mb = OPW'(t1_q); end
			S_C2:   begin ma = OPW'(k1_q); mb = OPW'(pct0_q); end
			S_C3:   begin ma = OPW'(k1_q); mb = OPW'(t1_q); end
			S_CA: begin
				ma = OPW'(k0_q); mb = OPW'(err_q); mw = 6'(DATA_WIDTH);
			end
			S_CB: begin
				ma = OPW'(k1_q); mb = OPW'(err_q); mw = 6'(DATA_WIDTH);
			end
			default: ;
		endcase
	end

	assign dnum   = (state_q == S_K0) ? pct0_q : pct1_q;
	assign dstart = ((state_q == S_K0) || (state_q == S_K1)) && !issued_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 24'd83886;
			qa_q <= 31'd16777;
			qb_q <= 31'd83886;
			rn_q <= 31'd8388608;
			c_q  <= 32'sd16777216;
		end else if (cfg_we) begin
			case (cfg_index)
				takf_pkg::REG_TIME_STEP:   dt_q <= cfg_value[23:0];
				takf_pkg::REG_ANGLE_NOISE: qa_q <= cfg_value[30:0];
				takf_pkg::REG_BIAS_NOISE:  qb_q <= cfg_value[30:0];
				takf_pkg::REG_MEAS_NOISE:  rn_q <= cfg_value[30:0];
				takf_pkg::REG_OBS_GAIN:    c_q  <= $signed(cfg_value);
				default: ;
			endcase
		end
	end

	// sequencer with filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wait_q   <= '0;
			issued_q <= 1'b0;
			ang_q    <= '0;
			bias_q   <= '0;
			p0_q     <= CW'(1) <<< COV_FRAC_BITS;
			p1_q     <= '0;
			p2_q     <= '0;
			p3_q     <= CW'(1) <<< COV_FRAC_BITS;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						gyro_q <= DATA_WIDTH'(in_data.gyro_rate);
						meas_q <= DATA_WIDTH'(in_data.measured_angle);
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					rate_q  <= DATA_WIDTH'(sat_d((OPW+2)'(gyro_q) - (OPW+2)'(bias_q)));
					wait_q  <= '0;
					state_q <= S_ANG;
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				S_K0, S_K1: begin
					if (ddone && issued_q) begin
						issued_q <= 1'b0;
						if (state_q == S_K0) begin
							k0_q <= dquo; state_q <= S_K1;
						end else begin
							k1_q <= dquo; wait_q <= '0; state_q <= S_T1;
						end
					end else begin
						issued_q <= 1'b1;
					end
				end
				default: begin
					// multiplier steps: issue, wait, then take result
					if (wait_q != 2'd2) begin
						wait_q <= wait_q + 2'd1;
					end else begin
						wait_q <= '0;
						case (state_q)
							S_ANG: begin
								ang_q <= DATA_WIDTH'(sat_d((OPW+2)'(ang_q)
									+ (OPW+2)'(my)));
								err_q <= DATA_WIDTH'(sat_d((OPW+2)'(meas_q)
									- (OPW+2)'(sat_d((OPW+2)'(ang_q) + (OPW+2)'(my)))));
								state_q <= S_P0;
							end
							S_P0: begin
								p0_q <= sat_c((CW+2)'(p0_q) + (CW+2)'(my)); state_q <= S_P1;
							end
							S_P1: begin
								p1_q <= sat_c((CW+2)'(p1_q) + (CW+2)'(my)); state_q <= S_P2;
							end
							S_P2: begin
								p2_q <= sat_c((CW+2)'(p2_q) + (CW+2)'(my)); state_q <= S_P3;
							end
							S_P3: begin
								p3_q <= sat_c((CW+2)'(p3_q) + (CW+2)'(my)); state_q <= S_PCT0;
							end
							S_PCT0: begin pct0_q <= CW'(my); state_q <= S_PCT1; end
							S_PCT1: begin pct1_q <= CW'(my); state_q <= S_E; end
							S_E: begin
								e_q <= sat_c((CW+2)'($signed({1'b0, rn_q})) + (CW+2)'(my));
								state_q <= S_K0;
							end
							S_T1: begin t1_q <= CW'(my); state_q <= S_C0; end
							S_C0: begin
								p0_q <= sat_c((CW+2)'(p0_q) - (CW+2)'(my)); state_q <= S_C1;
							end
							S_C1: begin
								p1_q <= sat_c((CW+2)'(p1_q) - (CW+2)'(my)); state_q <= S_C2;
							end
							S_C2: begin
								p2_q <= sat_c((CW+2)'(p2_q) - (CW+2)'(my)); state_q <= S_C3;
							end
							S_C3: begin
								p3_q <= sat_c((CW+2)'(p3_q) - (CW+2)'(my)); state_q <= S_CA;
							end
							S_CA: begin
								ang_q <= DATA_WIDTH'(sat_d((OPW+2)'(ang_q) + (OPW+2)'(my)));
								state_q <= S_CB;
							end
							S_CB: begin
								bias_q <= DATA_WIDTH'(sat_d((OPW+2)'(bias_q) + (OPW+2)'(my)));
								rate_q <= DATA_WIDTH'(sat_d((OPW+2)'(gyro_q)
									- (OPW+2)'(sat_d((OPW+2)'(bias_q) + (OPW+2)'(my)))));
								state_q <= S_OUT;
								res_q.angle_estimate <= sat_o(ang_q);
								res_q.bias_estimate  <= sat_o(DATA_WIDTH'(sat_d(
									(OPW+2)'(bias_q) + (OPW+2)'(my))));
								res_q.rate_estimate  <= sat_o(DATA_WIDTH'(sat_d(
									(OPW+2)'(gyro_q) - (OPW+2)'(sat_d((OPW+2)'(bias_q)
									+ (OPW+2)'(my))))));
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
			endcase
		end
	end

endmodule

FILE: hdl/takf_checker.sv
// port-level checks for the filter core, bound to the top level
`timescale 1ns / 1ps
module takf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input takf_pkg::out_item_t out_data
);
	// a result waiting to be taken holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no new item is taken while a result is shown
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// an accepted item does not yield a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");

	// after a result is taken the input opens again
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !in_stall)
		else $error("input stayed closed");

endmodule

bind tilt_angle_kalman_filter_core takf_checker u_takf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
